FILE: src/ffp_pkg.sv
// shared types, codes and sizes for the frame file placement block
`default_nettype none

package ffp_pkg;

    localparam int FRAME_NUMBER_WIDTH = 32;
    localparam int FN_BITS            = (FRAME_NUMBER_WIDTH < 32) ? FRAME_NUMBER_WIDTH : 32;
    localparam logic [31:0] FN_MASK   = 32'((64'd1 << FN_BITS) - 64'd1);

    localparam int IDX_W   = 33;
    localparam int RANK_W  = 8;
    localparam int COUNT_W = 9;
    localparam int FPB_W   = 16;
    localparam int BPF_W   = 16;
    localparam int CFG_W   = 16;
    localparam int ADD_W   = 34;

    localparam int DIV_STEPS = IDX_W;
    localparam int MUL_STEPS = FPB_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);

    localparam logic [1:0] CFG_WRITER_RANK      = 2'd0;
    localparam logic [1:0] CFG_WRITER_COUNT     = 2'd1;
    localparam logic [1:0] CFG_FRAMES_PER_BLOCK = 2'd2;
    localparam logic [1:0] CFG_BLOCKS_PER_FILE  = 2'd3;

    localparam logic [2:0] ST_CURRENT  = 3'd0;
    localparam logic [2:0] ST_PREVIOUS = 3'd1;
    localparam logic [2:0] ST_NEW      = 3'd2;
    localparam logic [2:0] ST_NEGATIVE = 3'd3;
    localparam logic [2:0] ST_RANK     = 3'd4;
    localparam logic [2:0] ST_NO_FILE  = 3'd5;

    typedef struct packed {
        logic        [31:0] frame_number;
        logic signed [31:0] offset_adjust;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]       status;
        logic [IDX_W-1:0] adjusted_offset;
        logic [IDX_W-1:0] target_file;
        logic [IDX_W-1:0] offset_in_file;
        logic [31:0]      missing_files;
    } t_out_beat;

endpackage

`default_nettype wire

FILE: src/frame_file_placement_unit.sv
// frame file placement: sequencer around one shared serial divide/multiply adder
//
// input channel: i_in_valid / o_in_stall with a frame number and a signed offset
// adjustment; a beat is taken when valid is high and stall is low. o_in_stall
// stays high from the cycle after a taken beat until its result is in the output
// register, so one frame is in work at a time.
// output channel: o_out_valid / i_out_stall with one result beat per input beat;
// the result register holds its beat while the receiver stalls, and a new input
// beat is taken meanwhile; the sequencer waits only if a second result is ready
// before the first is taken.
// a negative offset ends after the offset add, a wrong rank after the second division,
// zero blocks per file after two divisions and one multiply; the longest path, when a
// new file opens, is four 33-step restoring divisions and three 16-step shift-add
// multiplies, all on one 34-bit adder.
// configuration: plain write port, taken at each write-enable cycle; the user is to
// write it only while idle, which the block itself does not enforce; writing the
// writer rank restarts the file series.
// reset (synchronous, active low): registers return to rank 0, one writer, one
// frame per block, one unbounded file, no previous file; input stalls during reset.
`default_nettype none

module frame_file_placement_unit (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire  ffp_pkg::t_in_beat  i_in_data,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output ffp_pkg::t_out_beat       o_out_data,
    input  wire                      i_cfg_wr_en,
    input  wire  [1:0]               i_cfg_index,
    input  wire  [ffp_pkg::CFG_W-1:0] i_cfg_data
);
    import ffp_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_ADJ   = 14'b00000000000010,
        S_DIV1  = 14'b00000000000100,
        S_DIV2  = 14'b00000000001000,
        S_DIV3  = 14'b00000000010000,
        S_MOFF  = 14'b00000000100000,
        S_AOFF  = 14'b00000001000000,
        S_MFI   = 14'b00000010000000,
        S_AFI   = 14'b00000100000000,
        S_CMP   = 14'b00001000000000,
        S_DIV4  = 14'b00010000000000,
        S_MPREV = 14'b00100000000000,
        S_APREV = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_quo, n_quo;
    logic [FPB_W:0]     r_rem, n_rem;
    logic [IDX_W-1:0]   r_acc, n_acc;
    logic [FPB_W-1:0]   r_dvsr, n_dvsr;
    logic [31:0]        r_fn, n_fn;
    logic [31:0]        r_raw, n_raw;
    logic [IDX_W-1:0]   r_adj, n_adj;
    logic [FPB_W-1:0]   r_r1, n_r1;
    logic [IDX_W-1:0]   r_q, n_q;
    logic [IDX_W-1:0]   r_fi, n_fi;
    logic [IDX_W-1:0]   r_off, n_off;
    t_out_beat          r_res, n_res;
    t_out_beat          r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic [RANK_W-1:0]  r_rank, n_rank;
    logic [COUNT_W-1:0] r_wc, n_wc;
    logic [FPB_W-1:0]   r_fpb, n_fpb;
    logic [BPF_W-1:0]   r_bpf, n_bpf;
    logic [IDX_W-1:0]   r_cur, n_cur;
    logic [IDX_W-1:0]   r_prev, n_prev;
    logic               r_prev_present, n_prev_present;

    logic [ADD_W-1:0]   w_x, w_y;
    logic               w_cin;
    logic [ADD_W:0]     w_sum;
    logic [FPB_W:0]     w_rem_sh;
    logic               w_no_borrow;
    logic [IDX_W-1:0]   w_div_quo;
    logic [FPB_W:0]     w_div_rem;
    logic [IDX_W-1:0]   w_mul_acc;
    logic [FPB_W-1:0]   w_fpb_eff;
    logic [COUNT_W-1:0] w_wc_eff;
    logic               w_in_take;
    logic               w_out_take;

    assign w_fpb_eff  = (r_fpb == '0) ? FPB_W'(1) : r_fpb;
    assign w_wc_eff   = (r_wc == '0) ? COUNT_W'(1) : r_wc;
    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // shared adder operand select
    assign w_rem_sh = {r_rem[FPB_W-1:0], r_quo[IDX_W-1]};

    always_comb begin
        w_x   = '0;
        w_y   = '0;
        w_cin = 1'b0;
        unique case (r_state)
            S_ADJ: begin
                w_x = {2'b00, r_fn};
                w_y = {{2{r_raw[31]}}, r_raw};
            end
            S_DIV1, S_DIV2, S_DIV3, S_DIV4: begin
                w_x   = {{(ADD_W-FPB_W-1){1'b0}}, w_rem_sh};
                w_y   = ~{{(ADD_W-FPB_W){1'b0}}, r_dvsr};
                w_cin = 1'b1;
            end
            S_MOFF, S_MFI, S_MPREV: begin
                w_x = {1'b0, r_acc};
                w_y = {1'b0, r_quo};
            end
            S_AOFF: begin
                w_x = {1'b0, r_acc};
                w_y = {{(ADD_W-FPB_W){1'b0}}, r_r1};
            end
            S_AFI: begin
                w_x = {1'b0, r_acc};
                w_y = {{(ADD_W-RANK_W){1'b0}}, r_rank};
            end
            S_CMP: begin
                w_x = {1'b0, r_fi};
                w_y = ~{1'b0, r_cur};
            end
            S_APREV: begin
                w_x = {1'b0, r_cur};
                w_y = {1'b0, r_acc};
            end
            S_IDLE, S_DONE: begin
                w_x = '0;
            end
            default: begin
                w_x = '0;
            end
        endcase
    end

    assign w_sum       = {1'b0, w_x} + {1'b0, w_y} + {{ADD_W{1'b0}}, w_cin};
    assign w_no_borrow = w_sum[ADD_W];
    assign w_div_quo   = {r_quo[IDX_W-2:0], w_no_borrow};
    assign w_div_rem   = w_no_borrow ? w_sum[FPB_W:0] : w_rem_sh;
    assign w_mul_acc   = r_rem[0] ? w_sum[IDX_W-1:0] : r_acc;

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_quo          = r_quo;
        n_rem          = r_rem;
        n_acc          = r_acc;
        n_dvsr         = r_dvsr;
        n_fn           = r_fn;
        n_raw          = r_raw;
        n_adj          = r_adj;
        n_r1           = r_r1;
        n_q            = r_q;
        n_fi           = r_fi;
        n_off          = r_off;
        n_res          = r_res;
        n_out          = r_out;
        n_out_valid    = r_out_valid;
        n_rank         = r_rank;
        n_wc           = r_wc;
        n_fpb          = r_fpb;
        n_bpf          = r_bpf;
        n_cur          = r_cur;
        n_prev         = r_prev;
        n_prev_present = r_prev_present;

        if (w_out_take) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_fn    = i_in_data.frame_number & FN_MASK;
                    n_raw   = i_in_data.offset_adjust;
                    n_state = S_ADJ;
                end
            end
            S_ADJ: begin
                if (w_sum[ADD_W-1]) begin
                    n_res        = '0;
                    n_res.status = ST_NEGATIVE;
                    n_state      = S_DONE;
                end else begin
                    n_adj   = w_sum[IDX_W-1:0];
                    n_quo   = w_sum[IDX_W-1:0];
                    n_rem   = '0;
                    n_dvsr  = w_fpb_eff;
                    n_cnt   = DIV_LAST;
                    n_state = S_DIV1;
                end
            end
            S_DIV1, S_DIV2, S_DIV3, S_DIV4: begin
                n_quo = w_div_quo;
                n_rem = w_div_rem;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    unique case (r_state)
                        S_DIV1: begin
                            n_r1    = w_div_rem[FPB_W-1:0];
                            n_rem   = '0;
                            n_dvsr  = {{(FPB_W-COUNT_W){1'b0}}, w_wc_eff};
                            n_cnt   = DIV_LAST;
                            n_state = S_DIV2;
                        end
                        S_DIV2: begin
                            if ((w_wc_eff > COUNT_W'(1)) &&
                                (w_div_rem[COUNT_W-1:0] != {1'b0, r_rank})) begin
                                n_res                 = '0;
                                n_res.status          = ST_RANK;
                                n_res.adjusted_offset = r_adj;
                                n_state               = S_DONE;
                            end else if (r_bpf == '0) begin
                                n_acc   = '0;
                                n_rem   = {1'b0, w_fpb_eff};
                                n_cnt   = MUL_LAST;
                                n_state = S_MOFF;
                            end else begin
                                n_rem   = '0;
                                n_dvsr  = r_bpf;
                                n_cnt   = DIV_LAST;
                                n_state = S_DIV3;
                            end
                        end
                        S_DIV3: begin
                            n_q     = w_div_quo;
                            n_acc   = '0;
                            n_quo   = {{(IDX_W-FPB_W){1'b0}}, w_div_rem[FPB_W-1:0]};
                            n_rem   = {1'b0, w_fpb_eff};
                            n_cnt   = MUL_LAST;
                            n_state = S_MOFF;
                        end
                        default: begin
                            // missing file count, saturated to 32 bits
                            n_res.missing_files = w_div_quo[IDX_W-1] ? '1
                                                                     : w_div_quo[31:0];
                            n_acc   = '0;
                            n_rem   = {{(FPB_W-COUNT_W+1){1'b0}}, w_wc_eff};
                            n_cnt   = MUL_LAST;
                            n_state = S_MPREV;
                        end
                    endcase
                end
            end
            S_MOFF, S_MFI, S_MPREV: begin
                n_acc = w_mul_acc;
                n_quo = {r_quo[IDX_W-2:0], 1'b0};
                n_rem = {1'b0, r_rem[FPB_W:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    unique case (r_state)
                        S_MOFF:  n_state = S_AOFF;
                        S_MFI:   n_state = S_AFI;
                        default: n_state = S_APREV;
                    endcase
                end
            end
            S_AOFF: begin
                n_off = w_sum[IDX_W-1:0];
                if (r_bpf == '0) begin
                    n_res.status          = ST_CURRENT;
                    n_res.adjusted_offset = r_adj;
                    n_res.target_file     = r_cur;
                    n_res.offset_in_file  = w_sum[IDX_W-1:0];
                    n_res.missing_files   = '0;
                    n_state               = S_DONE;
                end else begin
                    n_acc   = '0;
                    n_quo   = r_q;
                    n_rem   = {{(FPB_W-COUNT_W+1){1'b0}}, w_wc_eff};
                    n_cnt   = MUL_LAST;
                    n_state = S_MFI;
                end
            end
            S_AFI: begin
                n_fi    = w_sum[IDX_W-1:0];
                n_state = S_CMP;
            end
            S_CMP: begin
                n_res.adjusted_offset = r_adj;
                n_res.target_file     = r_fi;
                n_res.offset_in_file  = r_off;
                n_res.missing_files   = '0;
                if (r_fi == r_cur) begin
                    n_res.status = ST_CURRENT;
                    n_state      = S_DONE;
                end else if (r_prev_present && (r_fi == r_prev)) begin
                    n_res.status = ST_PREVIOUS;
                    n_state      = S_DONE;
                end else if (w_sum[ADD_W]) begin
                    n_quo   = w_sum[IDX_W-1:0];
                    n_rem   = '0;
                    n_dvsr  = {{(FPB_W-COUNT_W){1'b0}}, w_wc_eff};
                    n_cnt   = DIV_LAST;
                    n_state = S_DIV4;
                end else begin
                    n_res.status         = ST_NO_FILE;
                    n_res.target_file    = '0;
                    n_res.offset_in_file = '0;
                    n_state              = S_DONE;
                end
            end
            S_APREV: begin
                n_prev         = w_sum[IDX_W-1:0];
                n_prev_present = 1'b1;
                n_cur          = r_fi;
                n_res.status   = ST_NEW;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_WRITER_RANK: begin
                    n_rank         = i_cfg_data[RANK_W-1:0];
                    n_cur          = {{(IDX_W-RANK_W){1'b0}}, i_cfg_data[RANK_W-1:0]};
                    n_prev_present = 1'b0;
                end
                CFG_WRITER_COUNT:     n_wc  = i_cfg_data[COUNT_W-1:0];
                CFG_FRAMES_PER_BLOCK: n_fpb = i_cfg_data[FPB_W-1:0];
                CFG_BLOCKS_PER_FILE:  n_bpf = i_cfg_data[BPF_W-1:0];
                default:              n_bpf = r_bpf;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_rank         <= '0;
            r_wc           <= COUNT_W'(1);
            r_fpb          <= FPB_W'(1);
            r_bpf          <= '0;
            r_cur          <= '0;
            r_prev         <= '0;
            r_prev_present <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_out_valid    <= n_out_valid;
            r_rank         <= n_rank;
            r_wc           <= n_wc;
            r_fpb          <= n_fpb;
            r_bpf          <= n_bpf;
            r_cur          <= n_cur;
            r_prev         <= n_prev;
            r_prev_present <= n_prev_present;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_acc  <= n_acc;
        r_dvsr <= n_dvsr;
        r_fn   <= n_fn;
        r_raw  <= n_raw;
        r_adj  <= n_adj;
        r_r1   <= n_r1;
        r_q    <= n_q;
        r_fi   <= n_fi;
        r_off  <= n_off;
        r_res  <= n_res;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire

FILE: src/ffp_checker.sv
// port-level checks for the frame file placement block, bound to the top level
`default_nettype none

module ffp_port_checker (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_in_valid,
    input wire                       o_in_stall,
    input wire ffp_pkg::t_in_beat    i_in_data,
    input wire                       o_out_valid,
    input wire                       i_out_stall,
    input wire ffp_pkg::t_out_beat   o_out_data,
    input wire                       i_cfg_wr_en,
    input wire [1:0]                 i_cfg_index,
    input wire [ffp_pkg::CFG_W-1:0]  i_cfg_data
);
    import ffp_pkg::*;

    logic w_unused;
    assign w_unused = ^{i_in_data, i_cfg_wr_en, i_cfg_index, i_cfg_data};

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed under stall");

    // one frame in work at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a frame is in work");

    // negative offset gives an all-zero result
    a_negative_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_NEGATIVE) |->
            (o_out_data.adjusted_offset == '0) && (o_out_data.target_file == '0) &&
            (o_out_data.offset_in_file == '0) && (o_out_data.missing_files == '0))
        else $error("negative offset result not cleared");

    // skipped files only reported when a new file opens
    a_missing_only_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_NEW) |-> (o_out_data.missing_files == '0))
        else $error("missing files reported without a new file");

    // rejected frames carry no placement
    a_reject_no_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_data.status == ST_RANK) ||
                        (o_out_data.status == ST_NO_FILE)) |->
            (o_out_data.target_file == '0) && (o_out_data.offset_in_file == '0))
        else $error("rejected frame carries a placement");

endmodule

bind frame_file_placement_unit ffp_port_checker u_ffp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .i_cfg_wr_en (i_cfg_wr_en),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

`default_nettype wire

FILE: test/ffp_checker.sv
// checker: predicts frame placements from observed beats and compares the block's results
`timescale 1ns / 100ps

module ffp_checker (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    input  wire                        i_in_stall,
    input  ffp_pkg::t_in_beat          i_in_data,
    input  wire                        i_out_valid,
    input  wire                        i_out_stall,
    input  ffp_pkg::t_out_beat         i_out_data,
    input  wire                        i_cfg_wr_en,
    input  wire  [1:0]                 i_cfg_index,
    input  wire  [ffp_pkg::CFG_W-1:0]  i_cfg_data,
    output logic [31:0]                o_fail_count,
    output logic [31:0]                o_pending
);
    import ffp_pkg::*;

    localparam longint unsigned IDX_MASK = 64'h1_FFFF_FFFF;

    logic [RANK_W-1:0]  rank_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [FPB_W-1:0]   fpb_reg;
    logic [BPF_W-1:0]   bpf_reg;

    longint unsigned cur_file;
    longint unsigned prev_file;
    bit              prev_open;

    t_out_beat placements[$];
    logic [31:0] errors = '0;

    assign o_fail_count = errors;

    initial o_pending = '0;

    function automatic t_out_beat place_frame(t_in_beat b);
        longint unsigned fn, raw, mag, adj, fpb, wc, bpf, first, off, fi, miss;
        t_out_beat r;
        r   = '0;
        fn  = 64'(b.frame_number & FN_MASK);
        raw = {32'd0, b.offset_adjust};
        fpb = (fpb_reg == 0) ? 64'd1 : 64'(fpb_reg);
        wc  = (count_reg == 0) ? 64'd1 : 64'(count_reg);
        bpf = 64'(bpf_reg);
        if (raw[31]) begin
            mag = 64'h1_0000_0000 - raw;
            if (mag > fn) begin
                r.status = ST_NEGATIVE;
                return r;
            end
            adj = fn - mag;
        end else begin
            adj = fn + raw;
        end
        r.adjusted_offset = adj[IDX_W-1:0];
        if (wc > 1 && ((adj / fpb) % wc) != 64'(rank_reg)) begin
            r.status = ST_RANK;
            return r;
        end
        first = (adj / (fpb * wc)) * fpb;
        if (bpf != 0) begin
            first = first % (bpf * fpb);
        end
        off = first + adj % fpb;
        r.offset_in_file = off[IDX_W-1:0];
        if (bpf == 0) begin
            r.status      = ST_CURRENT;
            r.target_file = cur_file[IDX_W-1:0];
            return r;
        end
        fi = ((((adj / fpb) / wc) / bpf) * wc + 64'(rank_reg)) & IDX_MASK;
        r.target_file = fi[IDX_W-1:0];
        if (fi == cur_file) begin
            r.status = ST_CURRENT;
        end else if (prev_open && fi == prev_file) begin
            r.status = ST_PREVIOUS;
        end else if (fi > cur_file) begin
            miss            = (fi - cur_file - 1) / wc;
            r.missing_files = (miss > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : miss[31:0];
            prev_file       = (cur_file + miss * wc) & IDX_MASK;
            prev_open       = 1'b1;
            cur_file        = fi;
            r.status        = ST_NEW;
        end else begin
            r.status         = ST_NO_FILE;
            r.target_file    = '0;
            r.offset_in_file = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors = errors + 1;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            rank_reg  = '0;
            count_reg = 9'd1;
            fpb_reg   = 16'd1;
            bpf_reg   = '0;
            cur_file  = 0;
            prev_file = 0;
            prev_open = 1'b0;
            placements.delete();
            o_pending <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_WRITER_RANK: begin
                        rank_reg  = i_cfg_data[RANK_W-1:0];
                        cur_file  = 64'(rank_reg);
                        prev_open = 1'b0;
                    end
                    CFG_WRITER_COUNT:     count_reg = i_cfg_data[COUNT_W-1:0];
                    CFG_FRAMES_PER_BLOCK: fpb_reg   = i_cfg_data[FPB_W-1:0];
                    CFG_BLOCKS_PER_FILE:  bpf_reg   = i_cfg_data[BPF_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (placements.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual status %0d",
                             $time, i_out_data.status);
                    errors = errors + 1;
                end else begin
                    want = placements.pop_front();
                    check_field("status", 64'(want.status), 64'(i_out_data.status));
                    check_field("adjusted_offset", 64'(want.adjusted_offset),
                                64'(i_out_data.adjusted_offset));
                    check_field("target_file", 64'(want.target_file),
                                64'(i_out_data.target_file));
                    check_field("offset_in_file", 64'(want.offset_in_file),
                                64'(i_out_data.offset_in_file));
                    check_field("missing_files", 64'(want.missing_files),
                                64'(i_out_data.missing_files));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                placements.push_back(place_frame(i_in_data));
            end
            o_pending <= placements.size();
        end
    end

endmodule

FILE: test/tb.sv
// testbench top: drives frames and register settings into the placement unit, gives the verdict
`timescale 1ns / 100ps

module tb;
    import ffp_pkg::*;

    localparam int RUN_LIMIT   = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 200;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    t_in_beat          in_data   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out_beat         out_data;
    logic              cfg_wr_en = 1'b0;
    logic [1:0]        cfg_index = CFG_WRITER_RANK;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic [31:0]       fail_count;
    logic [31:0]       pending;

    int              cycle_count = 0;
    bit              quiet       = 1'b0;
    bit              hold_req    = 1'b0;
    int              reg_rank, reg_count, reg_fpb, reg_bpf;
    longint unsigned block_cursor;

    always #5 clk = ~clk;

    frame_file_placement_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ffp_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // result side: random stalls, one long hold on request
    initial begin : result_side
        int run;
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else if (quiet) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                out_stall <= ($urandom_range(0, 2) == 0);
                run = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 4);
                repeat (run) @(posedge clk);
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
    endtask

    // rank last, since writing it restarts the file series
    task automatic set_regs(input int rank, input int count, input int fpb, input int bpf);
        reg_rank  = rank;
        reg_count = count;
        reg_fpb   = fpb;
        reg_bpf   = bpf;
        write_reg(CFG_WRITER_COUNT, count);
        write_reg(CFG_FRAMES_PER_BLOCK, fpb);
        write_reg(CFG_BLOCKS_PER_FILE, bpf);
        write_reg(CFG_WRITER_RANK, rank);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic idle_gap();
        int pick, n;
        pick = $urandom_range(0, 19);
        if (quiet || pick < 12) begin
            n = 0;
        end else if (pick < 19) begin
            n = $urandom_range(1, 3);
        end else begin
            n = $urandom_range(10, 40);
        end
        if (n != 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_frame(input logic [31:0] fn, input logic [31:0] adjust);
        idle_gap();
        in_valid              <= 1'b1;
        in_data.frame_number  <= fn;
        in_data.offset_adjust <= adjust;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // mostly frames that walk this writer's blocks forward, with some noise
    task automatic random_frame();
        longint unsigned wc, fpb, step, kmax, adj;
        longint          fn64;
        int              pick, adjust;
        wc   = (reg_count == 0) ? 1 : reg_count;
        fpb  = (reg_fpb == 0) ? 1 : reg_fpb;
        step = (reg_bpf == 0) ? 4 : reg_bpf;
        kmax = (64'h1_0000_0000 - 64'h200_0000) / (wc * fpb) - 1;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            send_frame($urandom, $urandom);
        end else if (pick < 20) begin
            adjust = -int'($urandom_range(0, 60));
            send_frame($urandom_range(0, 50), adjust);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
            end else if (pick < 75) begin
                block_cursor = block_cursor + 1;
            end else if (pick < 87) begin
                block_cursor = block_cursor + step * $urandom_range(1, 2);
            end else if (pick < 94) begin
                if (block_cursor >= step) block_cursor = block_cursor - step;
            end else begin
                block_cursor = block_cursor + step * $urandom_range(3, 30);
            end
            if (block_cursor > kmax) block_cursor = $urandom_range(0, 3);
            adj = (block_cursor * wc + longint'(reg_rank)) * fpb
                  + $urandom_range(0, 32'(fpb - 1));
            pick = $urandom_range(0, 3);
            if (pick == 0) begin
                adjust = $urandom;
            end else if (pick < 3) begin
                adjust = int'($urandom_range(0, 2000)) - 1000;
            end else begin
                adjust = 0;
            end
            fn64 = longint'(adj) - longint'(adjust);
            if (fn64 < 0 || fn64 > 64'hFFFF_FFFF) begin
                adjust = 0;
                fn64   = longint'(adj);
            end
            send_frame(fn64[31:0], adjust);
        end
    endtask

    task automatic random_phase(input int rank, input int count, input int fpb,
                                input int bpf, input int n_frames);
        set_regs(rank, count, fpb, bpf);
        block_cursor = 0;
        repeat (n_frames) random_frame();
        drain();
    endtask

    initial begin : stimulus
        int c;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // offset arithmetic with one unbounded file
        set_regs(0, 1, 1, 0);
        send_frame(32'd0, 32'd0);
        send_frame(32'd0, 32'hFFFF_FFFF);
        send_frame(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_frame(32'd5, -32'sd5);
        send_frame(32'h8000_0000, 32'h8000_0000);
        send_frame(32'h7FFF_FFFF, 32'h8000_0000);
        drain();

        // wrong rank, current, new, previous and older files
        set_regs(3, 4, 2, 2);
        send_frame(32'd0, 32'd0);
        send_frame(32'd7, -32'sd1);
        send_frame(32'd14, 32'd0);
        send_frame(32'd20, 32'd2);
        send_frame(32'd6, 32'd0);
        send_frame(32'd54, 32'd0);
        send_frame(32'd22, 32'd0);
        send_frame(32'd38, 32'd0);
        drain();

        // rank not below writer count
        set_regs(5, 3, 1, 1);
        send_frame(32'd100, 32'd0);
        send_frame(32'd7, 32'd2);
        drain();

        // zero writer count and zero frames per block
        set_regs(0, 0, 0, 3);
        send_frame(32'd10, 32'd0);
        send_frame(32'd40, -32'sd1);
        drain();

        set_regs(255, 256, 65535, 65535);
        send_frame(32'd16711425, 32'd0);
        send_frame(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        drain();

        // saturating missing-file count, then an older file
        set_regs(0, 1, 1, 1);
        send_frame(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_frame(32'd0, 32'd0);
        drain();

        hold_req = 1'b1;
        c = $urandom_range(2, 8);
        random_phase($urandom_range(0, c - 1), c, $urandom_range(1, 8),
                     $urandom_range(1, 4), 70);

        quiet = 1'b1;
        c = $urandom_range(2, 8);
        random_phase($urandom_range(0, c - 1), c, $urandom_range(1, 8),
                     $urandom_range(1, 4), 70);
        quiet = 1'b0;

        random_phase(0, 1, 1, 1, 60);
        random_phase(255, 256, 65535, 65535, 50);

        c = $urandom_range(1, 8);
        random_phase($urandom_range(0, c - 1), c, $urandom_range(1, 8), 0, 70);

        random_phase($urandom_range(3, 255), 3, $urandom_range(1, 4), 2, 20);

        c = $urandom_range(1, 256);
        random_phase($urandom_range(0, c - 1), c, $urandom_range(1, 300),
                     $urandom_range(1, 50), 80);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: frame_file_placement_unit.f
src/ffp_pkg.sv
src/frame_file_placement_unit.sv
src/ffp_checker.sv
test/ffp_checker.sv
test/tb.sv
